FILE: design/fps_pkg.sv
package fps_pkg;

  // fixed point format of the padding fraction
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned FRAC_WIDTH = 18;
  localparam logic [FRAC_WIDTH-1:0] FRAC_ONE = 18'd65536;
  localparam logic [FRAC_WIDTH-1:0] FRAC_MAX = 18'd131072;
  localparam logic [FRAC_BITS-1:0]  CEIL_BIAS = 16'hffff;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_CEIL,
    S_POW2,
    S_P3CHK,
    S_P5CHK,
    S_P7CHK,
    S_SHIFT,
    S_DONE
  } state_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_CEIL,
    OP_DOUBLE_BEST,
    OP_P5_INIT,
    OP_P3_STEP,
    OP_P7_INIT,
    OP_P5_STEP,
    OP_V_INIT,
    OP_V_SHIFT,
    OP_V_TAKE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic best_lt_least;
    logic p3_lt_best;
    logic p5_lt_best;
    logic p7_lt_best;
    logic v_lt_least;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/fps_in_if.sv
interface fps_in_if #(
  parameter int unsigned LENGTH_BITS = 16
);
  logic                                  valid;
  logic                                  ready;
  logic [LENGTH_BITS-1:0]                grid_length;
  logic [fps_pkg::FRAC_WIDTH-1:0]        pad_fraction;

  modport source (output valid, output grid_length, output pad_fraction, input ready);
  modport sink   (input valid, input grid_length, input pad_fraction, output ready);
  modport mon    (input valid, input grid_length, input pad_fraction, input ready);
endinterface

FILE: design/fps_out_if.sv
interface fps_out_if #(
  parameter int unsigned LENGTH_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [LENGTH_BITS+1:0] least_length;
  logic [LENGTH_BITS+2:0] padded_length;

  modport source (output valid, output least_length, output padded_length, input ready);
  modport sink   (input valid, input least_length, input padded_length, output ready);
  modport mon    (input valid, input least_length, input padded_length, input ready);
endinterface

FILE: design/fft_padding_size.sv
// fft_padding_size: padded FFT length for one grid axis
//
// input channel in_ch carries grid_length and pad_fraction (unsigned, 16
// fractional bits, values above 2.0 saturate to 2.0); output channel out_ch
// carries least_length = ceil(grid_length * (1 + fraction)) and
// padded_length, the smallest number at or above it with no prime factor
// other than 2, 3, 5 and 7
//
// one item at a time: a shift/compare datapath walks every product
// 3^a * 5^b * 7^c below the current best and doubles it up to the target,
// one step per cycle; after acceptance the controller loads the inputs,
// multiplies, takes the ceiling, then takes one step per doubling of the
// power-of-two start and one per product check, candidate shift and
// candidate take; a zero length needs no doubling and a single check
//
// in_ch.ready is high only while the controller is idle and out of reset;
// the output register lets the next item be taken while a result still
// waits, and a finished result is held in the controller until out_ch is free
// reset (synchronous) returns the controller to idle and drops out_ch.valid
module fft_padding_size #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  fps_in_if.sink     in_ch,
  fps_out_if.source  out_ch
);

  fps_pkg::dp_cmd_t    cmd;
  fps_pkg::dp_status_t status;
  logic                in_ready;

  // sequencing of the search
  fps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // multiply, ceiling, and the smooth number search registers
  fps_dp #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .grid_length  (in_ch.grid_length),
    .pad_fraction (in_ch.pad_fraction),
    .cmd          (cmd),
    .status       (status),
    .out_ch       (out_ch)
  );

endmodule

FILE: design/fps_ctrl.sv
module fps_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fps_pkg::dp_status_t  status,
  output fps_pkg::dp_cmd_t     cmd
);

  fps_pkg::state_t state;
  fps_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.op       = fps_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      fps_pkg::S_IDLE: begin
        // nothing is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.op     = fps_pkg::OP_LOAD;
          state_next = fps_pkg::S_MUL;
        end
      end
      fps_pkg::S_MUL: begin
        cmd.op     = fps_pkg::OP_MUL;
        state_next = fps_pkg::S_CEIL;
      end
      fps_pkg::S_CEIL: begin
        cmd.op     = fps_pkg::OP_CEIL;
        state_next = fps_pkg::S_POW2;
      end
      fps_pkg::S_POW2: begin
        if (status.best_lt_least) begin
          cmd.op = fps_pkg::OP_DOUBLE_BEST;
        end else begin
          state_next = fps_pkg::S_P3CHK;
        end
      end
      fps_pkg::S_P3CHK: begin
        if (status.p3_lt_best) begin
          cmd.op     = fps_pkg::OP_P5_INIT;
          state_next = fps_pkg::S_P5CHK;
        end else begin
          state_next = fps_pkg::S_DONE;
        end
      end
      fps_pkg::S_P5CHK: begin
        if (status.p5_lt_best) begin
          cmd.op     = fps_pkg::OP_P7_INIT;
          state_next = fps_pkg::S_P7CHK;
        end else begin
          cmd.op     = fps_pkg::OP_P3_STEP;
          state_next = fps_pkg::S_P3CHK;
        end
      end
      fps_pkg::S_P7CHK: begin
        if (status.p7_lt_best) begin
          cmd.op     = fps_pkg::OP_V_INIT;
          state_next = fps_pkg::S_SHIFT;
        end else begin
          cmd.op     = fps_pkg::OP_P5_STEP;
          state_next = fps_pkg::S_P5CHK;
        end
      end
      fps_pkg::S_SHIFT: begin
        if (status.v_lt_least) begin
          cmd.op = fps_pkg::OP_V_SHIFT;
        end else begin
          cmd.op     = fps_pkg::OP_V_TAKE;
          state_next = fps_pkg::S_P7CHK;
        end
      end
      fps_pkg::S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = fps_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fps_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/fps_dp.sv
module fps_dp #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [LENGTH_BITS-1:0]              grid_length,
  input  logic [fps_pkg::FRAC_WIDTH-1:0]      pad_fraction,
  input  fps_pkg::dp_cmd_t                    cmd,
  output fps_pkg::dp_status_t                 status,
  fps_out_if.source                           out_ch
);

  localparam int unsigned NUM_W   = LENGTH_BITS + fps_pkg::FRAC_WIDTH;
  localparam int unsigned LEAST_W = LENGTH_BITS + 2;
  localparam int unsigned BEST_W  = LENGTH_BITS + 3;
  // products of 3, 5, 7 stay below 7 * 2^(LENGTH_BITS+2)
  localparam int unsigned PW      = LENGTH_BITS + 5;

  logic [LENGTH_BITS-1:0]          len;
  logic [fps_pkg::FRAC_WIDTH-1:0]  scale;
  logic [NUM_W-1:0]                num;
  logic [LEAST_W-1:0]              least;
  logic [BEST_W-1:0]               best;
  logic [PW-1:0]                   p3;
  logic [PW-1:0]                   p5;
  logic [PW-1:0]                   p7;
  logic [PW-1:0]                   v;
  logic                            out_valid;
  logic [LEAST_W-1:0]              least_out;
  logic [BEST_W-1:0]               padded_out;

  logic [fps_pkg::FRAC_WIDTH-1:0]  frac_sat;
  logic [NUM_W-1:0]                num_biased;
  logic [PW-1:0]                   best_ext;
  logic [PW-1:0]                   least_ext;

  assign frac_sat   = (pad_fraction > fps_pkg::FRAC_MAX) ? fps_pkg::FRAC_MAX : pad_fraction;
  assign num_biased = num + NUM_W'(fps_pkg::CEIL_BIAS);
  assign best_ext   = PW'(best);
  assign least_ext  = PW'(least);

  assign status.best_lt_least = PW'(best) < least_ext;
  assign status.p3_lt_best    = p3 < best_ext;
  assign status.p5_lt_best    = p5 < best_ext;
  assign status.p7_lt_best    = p7 < best_ext;
  assign status.v_lt_least    = v < least_ext;
  assign status.out_free      = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    case (cmd.op)
      fps_pkg::OP_LOAD: begin
        len   <= grid_length;
        scale <= frac_sat + fps_pkg::FRAC_ONE;
      end
      fps_pkg::OP_MUL: begin
        num <= NUM_W'(len) * NUM_W'(scale);
      end
      fps_pkg::OP_CEIL: begin
        least <= num_biased[fps_pkg::FRAC_BITS +: LEAST_W];
        best  <= BEST_W'(1);
        p3    <= PW'(1);
      end
      fps_pkg::OP_DOUBLE_BEST: begin
        best <= {best[BEST_W-2:0], 1'b0};
      end
      fps_pkg::OP_P5_INIT: begin
        p5 <= p3;
      end
      fps_pkg::OP_P3_STEP: begin
        p3 <= {p3[PW-2:0], 1'b0} + p3;
      end
      fps_pkg::OP_P7_INIT: begin
        p7 <= p5;
      end
      fps_pkg::OP_P5_STEP: begin
        p5 <= {p5[PW-3:0], 2'b00} + p5;
      end
      fps_pkg::OP_V_INIT: begin
        v <= p7;
      end
      fps_pkg::OP_V_SHIFT: begin
        v <= {v[PW-2:0], 1'b0};
      end
      fps_pkg::OP_V_TAKE: begin
        if (v < best_ext) begin
          best <= v[BEST_W-1:0];
        end
        p7 <= {p7[PW-4:0], 3'b000} - p7;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      least_out  <= least;
      padded_out <= best;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.least_length  = least_out;
  assign out_ch.padded_length = padded_out;

endmodule

FILE: design/fps_checker.sv
module fps_checker #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   valid,
  input logic                   ready,
  input logic [LENGTH_BITS+1:0] least_length,
  input logic [LENGTH_BITS+2:0] padded_length
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(padded_length) && $stable(least_length))
    else $error("result dropped or changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !valid)
    else $error("result valid right after reset");

  a_not_below: assert property (@(posedge clk) disable iff (rst)
    valid |-> padded_length >= least_length && padded_length != 0)
    else $error("padded length below least length");

  // a power of two always lies within a factor of two
  a_within_double: assert property (@(posedge clk) disable iff (rst)
    valid && least_length != 0 |->
      padded_length < {least_length, 1'b0})
    else $error("padded length not the smallest candidate");

endmodule

bind fft_padding_size fps_checker #(
  .LENGTH_BITS (LENGTH_BITS)
) u_fps_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (out_ch.valid),
  .ready         (out_ch.ready),
  .least_length  (out_ch.least_length),
  .padded_length (out_ch.padded_length)
);

FILE: tb/padding_checker.sv
module padding_checker #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  fps_in_if.mon     in_mon,
  fps_out_if.mon    out_mon,
  output int        errors,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LENGTH_BITS+1:0] least;
    logic [LENGTH_BITS+2:0] padded;
  } lengths_t;

  lengths_t lengths_due_q[$];
  int fail_count = 0;

  // smallest number >= target with no prime factor above 7
  function automatic logic [63:0] next_smooth_length(input logic [63:0] target);
    logic [63:0] best, p3, p5, p7, v;
    best = 64'd1;
    while (best < target) best = best << 1;
    for (p3 = 64'd1; p3 < best; p3 = p3 * 3) begin
      for (p5 = p3; p5 < best; p5 = p5 * 5) begin
        for (p7 = p5; p7 < best; p7 = p7 * 7) begin
          v = p7;
          while (v < target) v = v << 1;
          if (v < best) best = v;
        end
      end
    end
    return best;
  endfunction

  function automatic lengths_t predict_lengths(
      input logic [LENGTH_BITS-1:0] len,
      input logic [fps_pkg::FRAC_WIDTH-1:0] frac);
    logic [63:0] scale, least, padded;
    lengths_t r;
    scale = (frac > fps_pkg::FRAC_MAX) ? 64'(fps_pkg::FRAC_MAX) : 64'(frac);
    scale = scale + (64'd1 << fps_pkg::FRAC_BITS);
    least = (64'(len) * scale + 64'(fps_pkg::CEIL_BIAS)) >> fps_pkg::FRAC_BITS;
    padded = next_smooth_length(least);
    r.least = least[LENGTH_BITS+1:0];
    r.padded = padded[LENGTH_BITS+2:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    if (fail_count < 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    lengths_t want;
    if (!rst) begin
      // result side first: a result never belongs to the item taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (lengths_due_q.size() == 0) begin
          report_mismatch("unexpected result least_length", -1,
                          longint'(out_mon.least_length));
        end else begin
          want = lengths_due_q.pop_front();
          if (out_mon.least_length !== want.least)
            report_mismatch("least_length", longint'(want.least),
                            longint'(out_mon.least_length));
          if (out_mon.padded_length !== want.padded)
            report_mismatch("padded_length", longint'(want.padded),
                            longint'(out_mon.padded_length));
        end
      end
      if (in_mon.valid && in_mon.ready)
        lengths_due_q = {lengths_due_q,
                         predict_lengths(in_mon.grid_length, in_mon.pad_fraction)};
    end
    errors <= fail_count;
    pending <= lengths_due_q.size();
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEN_BITS = 16;
  localparam int unsigned FRAC_W = fps_pkg::FRAC_WIDTH;
  // longest legal wait with no handshake: a large length walk plus sender
  // gap and receiver stall, taken several times over
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 117;
  localparam int TAIL_CYCLES = 64;

  logic clk;
  logic rst;
  bit   calm;    // when set, neither side inserts idle cycles
  int   errors;
  int   pending;
  int   idle_cycles = 0;

  fps_in_if  #(.LENGTH_BITS(LEN_BITS)) in_ch ();
  fps_out_if #(.LENGTH_BITS(LEN_BITS)) out_ch ();

  fft_padding_size #(.LENGTH_BITS(LEN_BITS)) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  padding_checker #(.LENGTH_BITS(LEN_BITS)) u_padding_checker (
    .clk     (clk),
    .rst     (rst),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: too long without any handshake means the block hung
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: per result, drop ready for a random stall (none when calm) before raising it
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      // hold ready until a result is taken
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // offer one item after a random gap, return once it is taken
  task automatic send_item(input logic [LEN_BITS-1:0] len,
                           input logic [FRAC_W-1:0] frac);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.grid_length  <= len;
    in_ch.pad_fraction <= frac;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // random fraction: mostly the legal range, some above 2.0, some edge values
  function automatic logic [FRAC_W-1:0] pick_fraction();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return FRAC_W'($urandom_range(0, 131072));
    if (pick < 8) return FRAC_W'($urandom);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return fps_pkg::FRAC_ONE;
      2: return fps_pkg::FRAC_MAX;
      3: return FRAC_W'(1);
      default: return fps_pkg::FRAC_MAX - 18'd1;
    endcase
  endfunction

  initial begin
    logic [LEN_BITS-1:0]   len;
    int                    pick;
    logic [LEN_BITS-1:0]   dir_len[$];
    logic [FRAC_W-1:0]     dir_frac[$];

    calm = 1'b0;
    rst <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.grid_length  <= '0;
    in_ch.pad_fraction <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: zero length, smallest and largest lengths, fraction extremes,
    // saturation above 2.0, exact smooth targets, targets near 11 and 13
    dir_len = '{16'd0,     16'd0,     16'd1,     16'd1,     16'd1,     16'd1,
                16'd1,     16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd1024,
                16'd32768, 16'd32768, 16'd11,    16'd13,    16'd121,   16'd169,
                16'd3,     16'd40000, 16'hAAAA,  16'h5555,  16'd7};
    dir_frac = '{18'd0,     18'h3FFFF, 18'd0,     18'd1,     18'd131071, 18'd131072,
                 18'd131073, 18'd0,    18'd131072, 18'h3FFFF, 18'd65536, 18'd0,
                 18'd0,     18'd65536, 18'd0,     18'd0,     18'd0,     18'd0,
                 18'd65535, 18'd131072, 18'h15555, 18'h2AAAA, 18'd65536};
    foreach (dir_len[i]) send_item(dir_len[i], dir_frac[i]);

    // random: mostly short lengths (fast walk), a few full-range ones;
    // every third block of 20 items runs without idle cycles
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = ((n / 20) % 3) == 2;
      pick = $urandom_range(0, 19);
      if (pick < 14)      len = LEN_BITS'($urandom_range(1, 255));
      else if (pick < 17) len = LEN_BITS'($urandom_range(256, 4095));
      else                len = LEN_BITS'($urandom);
      send_item(len, pick_fraction());
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    // drain outstanding results, then give late extras a chance to show up
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
